// ===== hw/rtl/iss_pkg.sv =====
`default_nettype none

package iss_pkg;

  // fixed field widths
  localparam int OP_W     = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // packed stream widths, rounded up to whole bytes
  localparam int IN_BITS   = OP_W + VALUE_W + POS_W;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = VALUE_W + STATUS_W + COUNT_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // field offsets inside tdata
  localparam int IN_OP_LSB    = 0;
  localparam int IN_VALUE_LSB = OP_W;
  localparam int IN_POS_LSB   = OP_W + VALUE_W;
  localparam int OUT_RD_LSB     = 0;
  localparam int OUT_STATUS_LSB = VALUE_W;
  localparam int OUT_COUNT_LSB  = VALUE_W + STATUS_W;

  localparam int DEFAULT_CAPACITY = 16;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_INSERT     = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_BACK   = 3'd4,
    OP_ERASE      = 3'd5,
    OP_READ       = 3'd6,
    OP_NOP        = 3'd7
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;  // open a gap at target, shift toward the back
    logic del;  // close the gap at target, shift toward the front
    logic rd;   // drive the cell at target onto the read chain
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/iss_cell.sv =====
`default_nettype none

module iss_cell #(
  parameter int CMP_W = 5,
  parameter int IDX   = 0
) (
  input  wire                              clk,
  input  wire iss_pkg::cell_cmd_t          cmd,
  input  wire  [CMP_W-1:0]                 target,
  input  wire  [iss_pkg::VALUE_W-1:0]      value_in,
  input  wire  [iss_pkg::VALUE_W-1:0]      left_in,
  input  wire  [iss_pkg::VALUE_W-1:0]      right_in,
  input  wire  [iss_pkg::VALUE_W-1:0]      rd_in,
  output logic [iss_pkg::VALUE_W-1:0]      data_out,
  output logic [iss_pkg::VALUE_W-1:0]      rd_out
);

  localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(IDX);

  logic [iss_pkg::VALUE_W-1:0] data_r;
  logic                        at_tgt;
  logic                        past_tgt;

  // position of this cell relative to the target
  assign at_tgt   = (target == MY_IDX);
  assign past_tgt = (MY_IDX > target);

  // entry storage, shifts with its neighbors
  always_ff @(posedge clk) begin
    if (cmd.ins && at_tgt) begin
      data_r <= value_in;
    end else if (cmd.ins && past_tgt) begin
      data_r <= left_in;
    end else if (cmd.del && (at_tgt || past_tgt)) begin
      data_r <= right_in;
    end
  end

  assign data_out = data_r;

  // read chain, only the target cell contributes
  assign rd_out = (cmd.rd && at_tgt) ? (rd_in | data_r) : rd_in;

endmodule

`default_nettype wire

// ===== hw/rtl/iss_ctrl.sv =====
`default_nettype none

module iss_ctrl #(
  parameter int CAPACITY = iss_pkg::DEFAULT_CAPACITY,
  parameter int CMP_W    = 5
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              fire,
  input  wire  [iss_pkg::OP_W-1:0]         op,
  input  wire  [iss_pkg::POS_W-1:0]        position,
  output iss_pkg::cell_cmd_t               cmd,
  output logic [CMP_W-1:0]                 target,
  output iss_pkg::status_t                 status,
  output logic [iss_pkg::COUNT_W-1:0]      count
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CMP_W-1:0] CAP_VAL = CMP_W'(CAPACITY);

  iss_pkg::op_t       op_e;
  iss_pkg::cell_cmd_t cmd_raw;
  logic [CNT_W-1:0]   occ_r;
  logic [CNT_W-1:0]   occ_nxt;
  logic [CMP_W-1:0]   occ_ext;
  logic [CMP_W-1:0]   pos_ext;
  logic [CMP_W-1:0]   occ_new;

  assign op_e    = iss_pkg::op_t'(op);
  assign occ_ext = CMP_W'(occ_r);
  assign pos_ext = CMP_W'(position);

  // decode operation into target, status and cell command
  always_comb begin
    cmd_raw = '0;
    target  = '0;
    status  = iss_pkg::ST_DONE;
    occ_new = occ_ext;
    case (op_e)
      iss_pkg::OP_PUSH_FRONT, iss_pkg::OP_PUSH_BACK, iss_pkg::OP_INSERT: begin
        if (op_e == iss_pkg::OP_PUSH_FRONT) begin
          target = '0;
        end else if (op_e == iss_pkg::OP_PUSH_BACK) begin
          target = occ_ext;
        end else begin
          target = pos_ext;
        end
        if (target > occ_ext) begin
          status = iss_pkg::ST_RANGE;
        end else if (occ_ext >= CAP_VAL) begin
          status = iss_pkg::ST_FULL;
        end else begin
          cmd_raw.ins = 1'b1;
          occ_new     = occ_ext + 1'b1;
        end
      end
      iss_pkg::OP_POP_FRONT, iss_pkg::OP_POP_BACK: begin
        target = (op_e == iss_pkg::OP_POP_FRONT) ? '0 : (occ_ext - 1'b1);
        if (occ_ext == '0) begin
          status = iss_pkg::ST_RANGE;
        end else begin
          cmd_raw.del = 1'b1;
          occ_new     = occ_ext - 1'b1;
        end
      end
      iss_pkg::OP_ERASE: begin
        target = pos_ext;
        if (pos_ext >= occ_ext) begin
          status = iss_pkg::ST_RANGE;
        end else begin
          cmd_raw.del = 1'b1;
          occ_new     = occ_ext - 1'b1;
        end
      end
      iss_pkg::OP_READ: begin
        target = pos_ext;
        if (pos_ext >= occ_ext) begin
          status = iss_pkg::ST_RANGE;
        end else begin
          cmd_raw.rd = 1'b1;
        end
      end
      default: begin
        cmd_raw = '0;
      end
    endcase
  end

  // cells only move on an accepted transaction
  assign cmd.ins = cmd_raw.ins & fire;
  assign cmd.del = cmd_raw.del & fire;
  assign cmd.rd  = cmd_raw.rd;

  assign occ_nxt = occ_new[CNT_W-1:0];
  assign count   = occ_new[iss_pkg::COUNT_W-1:0];

  // occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else if (fire) begin
      occ_r <= occ_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/indexed_sequence_store_top.sv =====
// latency: a result is registered and appears in the cycle after its transaction is accepted
// throughput: one transaction per cycle while the result side keeps taking results
// the read path runs through the row of cells, one cell per stored entry
// reset clears the occupancy and the result valid flag; result data and entry cells are not reset
`default_nettype none

module indexed_sequence_store_top #(
  parameter int CAPACITY = iss_pkg::DEFAULT_CAPACITY
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_tvalid,
  output logic                               in_tready,
  // operation[2:0], value[34:3], position[39:35]
  input  wire  [iss_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                               out_tvalid,
  input  wire                                out_tready,
  // read_value[31:0], status[33:32], count[38:34]
  output logic [iss_pkg::OUT_DATA_W-1:0]     out_tdata
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > iss_pkg::POS_W) ? CNT_W : iss_pkg::POS_W;
  localparam int VW    = iss_pkg::VALUE_W;

  logic                         fire;
  logic [iss_pkg::OP_W-1:0]     in_op;
  logic [VW-1:0]                in_value;
  logic [iss_pkg::POS_W-1:0]    in_pos;
  iss_pkg::cell_cmd_t           cmd;
  logic [CMP_W-1:0]             target;
  iss_pkg::status_t             status;
  logic [iss_pkg::COUNT_W-1:0]  count;
  logic [VW-1:0]                cell_data [CAPACITY];
  logic [VW-1:0]                rd_chain  [CAPACITY+1];
  logic                         out_valid_r;
  logic [iss_pkg::OUT_DATA_W-1:0] out_data_r;
  logic [iss_pkg::OUT_DATA_W-1:0] out_data_nxt;

  // unpack input transaction
  assign in_op    = in_tdata[iss_pkg::IN_OP_LSB +: iss_pkg::OP_W];
  assign in_value = in_tdata[iss_pkg::IN_VALUE_LSB +: VW];
  assign in_pos   = in_tdata[iss_pkg::IN_POS_LSB +: iss_pkg::POS_W];

  assign in_tready = !out_valid_r || out_tready;
  assign fire      = in_tvalid && in_tready;

  iss_ctrl #(
    .CAPACITY (CAPACITY),
    .CMP_W    (CMP_W)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .op       (in_op),
    .position (in_pos),
    .cmd      (cmd),
    .target   (target),
    .status   (status),
    .count    (count)
  );

  // row of entry cells, front at index 0
  assign rd_chain[0] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VW-1:0] left_val;
    logic [VW-1:0] right_val;
    if (i == 0) begin : g_first
      assign left_val = '0;
    end else begin : g_mid_l
      assign left_val = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_val = cell_data[i];
    end else begin : g_mid_r
      assign right_val = cell_data[i+1];
    end
    iss_cell #(
      .CMP_W (CMP_W),
      .IDX   (i)
    ) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .target   (target),
      .value_in (in_value),
      .left_in  (left_val),
      .right_in (right_val),
      .rd_in    (rd_chain[i]),
      .data_out (cell_data[i]),
      .rd_out   (rd_chain[i+1])
    );
  end

  // pack result
  always_comb begin
    out_data_nxt = '0;
    out_data_nxt[iss_pkg::OUT_RD_LSB +: VW] = rd_chain[CAPACITY];
    out_data_nxt[iss_pkg::OUT_STATUS_LSB +: iss_pkg::STATUS_W] = status;
    out_data_nxt[iss_pkg::OUT_COUNT_LSB +: iss_pkg::COUNT_W] = count;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/iss_checker.sv =====
`default_nettype none

module iss_checker #(
  parameter int CAPACITY = iss_pkg::DEFAULT_CAPACITY
) (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              in_tvalid,
  input wire                              in_tready,
  input wire [iss_pkg::IN_DATA_W-1:0]     in_tdata,
  input wire                              out_tvalid,
  input wire                              out_tready,
  input wire [iss_pkg::OUT_DATA_W-1:0]    out_tdata
);

  localparam logic [iss_pkg::COUNT_W-1:0] CAP_CNT = iss_pkg::COUNT_W'(CAPACITY);

  logic [iss_pkg::VALUE_W-1:0]  rd_val;
  logic [iss_pkg::STATUS_W-1:0] st_val;
  logic [iss_pkg::COUNT_W-1:0]  cnt_val;
  logic [iss_pkg::OP_W-1:0]     op_val;

  assign rd_val  = out_tdata[iss_pkg::OUT_RD_LSB +: iss_pkg::VALUE_W];
  assign st_val  = out_tdata[iss_pkg::OUT_STATUS_LSB +: iss_pkg::STATUS_W];
  assign cnt_val = out_tdata[iss_pkg::OUT_COUNT_LSB +: iss_pkg::COUNT_W];
  assign op_val  = in_tdata[iss_pkg::IN_OP_LSB +: iss_pkg::OP_W];

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // every accepted transaction gives a result in the next cycle
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("missing result after accepted transaction");

  // a failed operation returns zero data
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st_val != iss_pkg::ST_DONE |-> rd_val == '0)
    else $error("nonzero read value on failed operation");

  // full status only when the store holds its capacity
  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st_val == iss_pkg::ST_FULL |-> cnt_val == CAP_CNT)
    else $error("full status with store not full");

  // a nop transaction gives done with zero data
  a_nop: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && op_val == iss_pkg::OP_NOP |=>
      st_val == iss_pkg::ST_DONE && rd_val == '0)
    else $error("nop transaction gave a non-neutral result");

endmodule

bind indexed_sequence_store_top iss_checker #(
  .CAPACITY (CAPACITY)
) u_iss_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
